// ===== rtl/spectral_gate_bin_unit_assert.svh =====
// Assertion macros for the spectral gate bin unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SPECTRAL_GATE_BIN_UNIT_ASSERT_SVH
`define SPECTRAL_GATE_BIN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SGB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGB_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGB_ASSERT(label, clk, rst_n, prop, msg)
`define SGB_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

// ===== rtl/sgb_pkg.sv =====
// Shared types and constants for the spectral gate bin unit.
// No dependencies; imported by every module of the block.
package sgb_pkg;

    localparam int SGB_FFT_POINTS  = 1024;
    localparam int SGB_SAMPLE_BITS = 16;

    localparam int SGB_CFG_IDX_W  = 8;
    localparam int SGB_CFG_DATA_W = 33;

    localparam logic [SGB_CFG_IDX_W-1:0] SGB_REG_GATE_FLOOR   = 8'd0;
    localparam logic [SGB_CFG_IDX_W-1:0] SGB_REG_TILT_GAIN    = 8'd1;
    localparam logic [SGB_CFG_IDX_W-1:0] SGB_REG_TILT_STEP    = 8'd2;
    localparam logic [SGB_CFG_IDX_W-1:0] SGB_REG_INVERT_GATE  = 8'd3;

    localparam int SGB_THR_W  = 31;
    localparam int SGB_GAIN_W = 17;
    localparam int SGB_STEP_W = 33;

    localparam int SGB_ONE_SHIFT  = 30;
    localparam int SGB_GAIN_SHIFT = 15;
    localparam int SGB_ROUND_SHIFT = 14;
    localparam int SGB_ROUND_ADD  = 8192;
    localparam int SGB_CMP_SHIFT  = 32;

    localparam int SGB_WEIGHT_W = 18;
    localparam logic [SGB_WEIGHT_W-1:0] SGB_WEIGHT_MAX = 18'h3FFFF;

    localparam int SGB_LAT = 6;

    typedef struct packed {
        logic [SGB_THR_W-1:0]         gate_floor;
        logic signed [SGB_GAIN_W-1:0] tilt_gain;
        logic signed [SGB_STEP_W-1:0] tilt_step;
        logic                         invert_gate;
    } t_cfg;

endpackage

// ===== rtl/sgb_weight.sv =====
// Tilt weight pipeline: index times step, offset sum, clamp, round and saturate.
// Depends on sgb_pkg; three register stages.
module sgb_weight #(
    parameter int IDX_W = 10
) (
    input  logic                                i_clk,
    input  sgb_pkg::t_cfg                       i_cfg,
    input  logic [IDX_W-1:0]                    i_bin_index,
    output logic [sgb_pkg::SGB_WEIGHT_W-1:0]    o_weight
);
    import sgb_pkg::*;

    localparam int PROD_W = IDX_W + 1 + SGB_STEP_W;
    localparam int W30_W  = PROD_W + 1;
    localparam int SUM_W  = SGB_GAIN_W + SGB_GAIN_SHIFT;
    localparam int SH_W   = W30_W - SGB_ROUND_SHIFT;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [W30_W-1:0]  n_w30;
    logic signed [W30_W-1:0]  r_w30;
    logic signed [W30_W-1:0]  one_q30;
    logic signed [W30_W-1:0]  gain_ext;
    logic [W30_W-1:0]         rnd;
    logic [SH_W-1:0]          shifted;
    logic [SGB_WEIGHT_W-1:0]  n_weight;
    logic [SGB_WEIGHT_W-1:0]  r_weight;

    assign n_prod   = $signed({1'b0, i_bin_index}) * i_cfg.tilt_step;
    assign one_q30  = W30_W'(1) << SGB_ONE_SHIFT;
    assign gain_ext = {{(W30_W-SUM_W){i_cfg.tilt_gain[SGB_GAIN_W-1]}},
                       i_cfg.tilt_gain, {SGB_GAIN_SHIFT{1'b0}}};
    assign n_w30    = one_q30 + gain_ext - {r_prod[PROD_W-1], r_prod};

    assign rnd     = {1'b0, r_w30[W30_W-2:0]} + W30_W'(SGB_ROUND_ADD);
    assign shifted = rnd[W30_W-1:SGB_ROUND_SHIFT];

    always_comb begin
        if (r_w30[W30_W-1]) begin
            n_weight = '0;
        end else if (|shifted[SH_W-1:SGB_WEIGHT_W]) begin
            n_weight = SGB_WEIGHT_MAX;
        end else begin
            n_weight = shifted[SGB_WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_w30    <= n_w30;
        r_weight <= n_weight;
    end

    assign o_weight = r_weight;

endmodule

// ===== rtl/sgb_mag.sv =====
// Squared magnitude pipeline: two squares, their sum, and one alignment stage.
// Depends on sgb_pkg; three register stages.
module sgb_mag #(
    parameter int SW = 16
) (
    input  logic                 i_clk,
    input  logic signed [SW-1:0] i_re,
    input  logic signed [SW-1:0] i_im,
    output logic [2*SW-1:0]      o_mag
);
    import sgb_pkg::*;

    localparam int MAG_W = 2 * SW;

    logic signed [MAG_W-1:0] n_rr;
    logic signed [MAG_W-1:0] n_ii;
    logic signed [MAG_W-1:0] r_rr;
    logic signed [MAG_W-1:0] r_ii;
    logic [MAG_W-1:0]        n_mag;
    logic [MAG_W-1:0]        r_mag;
    logic [MAG_W-1:0]        r_mag_d;

    assign n_rr  = i_re * i_re;
    assign n_ii  = i_im * i_im;
    assign n_mag = {1'b0, r_rr[MAG_W-2:0]} + {1'b0, r_ii[MAG_W-2:0]};

    always_ff @(posedge i_clk) begin
        r_rr    <= n_rr;
        r_ii    <= n_ii;
        r_mag   <= n_mag;
        r_mag_d <= r_mag;
    end

    assign o_mag = r_mag_d;

endmodule

// ===== rtl/sgb_gate.sv =====
// Gate: scaled magnitude times weight squared below threshold, invertible.
// Depends on sgb_pkg; two register stages, the compare feeds the output stage.
module sgb_gate #(
    parameter int MAG_W = 32
) (
    input  logic                               i_clk,
    input  sgb_pkg::t_cfg                      i_cfg,
    input  logic [MAG_W-1:0]                   i_mag,
    input  logic [sgb_pkg::SGB_WEIGHT_W-1:0]   i_weight,
    output logic                               o_below
);
    import sgb_pkg::*;

    localparam int PW   = MAG_W + SGB_WEIGHT_W;
    localparam int PL   = PW / 2;
    localparam int PH   = PW - PL;
    localparam int PRW  = PW + SGB_WEIGHT_W;
    localparam int HI_W = PRW - SGB_CMP_SHIFT;
    localparam int CW   = (HI_W > SGB_THR_W) ? HI_W : SGB_THR_W;

    logic [PW-1:0]               r_p;
    logic [SGB_WEIGHT_W-1:0]     r_w;
    logic [PL+SGB_WEIGHT_W-1:0]  r_pp_lo;
    logic [PH+SGB_WEIGHT_W-1:0]  r_pp_hi;
    logic [PRW-1:0]              full;
    logic [HI_W-1:0]             hi;
    logic                        below_raw;

    always_ff @(posedge i_clk) begin
        r_p     <= i_mag * i_weight;
        r_w     <= i_weight;
        r_pp_lo <= r_p[PL-1:0] * r_w;
        r_pp_hi <= r_p[PW-1:PL] * r_w;
    end

    assign full      = {r_pp_hi, {PL{1'b0}}} + PRW'(r_pp_lo);
    assign hi        = full[PRW-1:SGB_CMP_SHIFT];
    assign below_raw = CW'(hi) < CW'(i_cfg.gate_floor);
    assign o_below   = below_raw ^ i_cfg.invert_gate;

endmodule

// ===== rtl/spectral_gate_bin_unit.sv =====
// Top level of the spectral gate bin unit: configuration registers, request
// pipeline, payload delay line and output register. Depends on sgb_pkg,
// sgb_weight, sgb_mag, sgb_gate and spectral_gate_bin_unit_assert.svh.
//
//  Channel   Handshake                      Payload
//  request   i_start, o_busy                i_bin_index, i_bin_real, i_bin_imag,
//                                           i_frame_last
//  result    o_result_strobe (one cycle)    o_out_real, o_out_imag, o_gated,
//                                           o_out_last
//  config    i_cfg_valid, o_cfg_ready       i_cfg_index, i_cfg_data
//
//  A request may be issued every cycle while o_busy is low; its result passes
//  the six register stages of the weight, square and compare pipe and output
//  register. Results leave in request order and the pipeline never stalls.
//  Reset is synchronous, active low, and clears the configuration registers
//  to zero and the valid bits; o_busy is high during reset and the cycle
//  after it.
module spectral_gate_bin_unit #(
    parameter int FFT_POINTS  = sgb_pkg::SGB_FFT_POINTS,
    parameter int SAMPLE_BITS = sgb_pkg::SGB_SAMPLE_BITS,
    localparam int IDX_W      = $clog2(FFT_POINTS / 2 + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [IDX_W-1:0]                     i_bin_index,
    input  logic signed [SAMPLE_BITS-1:0]        i_bin_real,
    input  logic signed [SAMPLE_BITS-1:0]        i_bin_imag,
    input  logic                                 i_frame_last,
    output logic                                 o_result_strobe,
    output logic signed [SAMPLE_BITS-1:0]        o_out_real,
    output logic signed [SAMPLE_BITS-1:0]        o_out_imag,
    output logic                                 o_gated,
    output logic                                 o_out_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sgb_pkg::SGB_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sgb_pkg::SGB_CFG_DATA_W-1:0]   i_cfg_data
);
    import sgb_pkg::*;

`include "spectral_gate_bin_unit_assert.svh"

    localparam int SW    = SAMPLE_BITS;
    localparam int MAG_W = 2 * SW;

    t_cfg                    r_cfg;
    t_cfg                    n_cfg;
    logic                    r_ready;
    logic                    accept;
    logic [SGB_LAT-1:0]      r_vld;
    logic signed [SW-1:0]    r_re_d   [SGB_LAT-1];
    logic signed [SW-1:0]    r_im_d   [SGB_LAT-1];
    logic                    r_last_d [SGB_LAT-1];
    logic [SGB_WEIGHT_W-1:0] weight;
    logic [MAG_W-1:0]        mag;
    logic                    below;
    logic signed [SW-1:0]    r_out_real;
    logic signed [SW-1:0]    r_out_imag;
    logic                    r_gated;
    logic                    r_out_last;

    assign accept      = i_start & r_ready;
    assign o_busy      = ~r_ready;
    assign o_cfg_ready = r_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && r_ready) begin
            unique case (i_cfg_index)
                SGB_REG_GATE_FLOOR:   n_cfg.gate_floor   = i_cfg_data[SGB_THR_W-1:0];
                SGB_REG_TILT_GAIN:    n_cfg.tilt_gain    = i_cfg_data[SGB_GAIN_W-1:0];
                SGB_REG_TILT_STEP:    n_cfg.tilt_step    = i_cfg_data[SGB_STEP_W-1:0];
                SGB_REG_INVERT_GATE:  n_cfg.invert_gate  = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '0;
            r_ready <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_cfg   <= n_cfg;
            r_ready <= 1'b1;
            r_vld   <= {r_vld[SGB_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_re_d[0]   <= i_bin_real;
        r_im_d[0]   <= i_bin_imag;
        r_last_d[0] <= i_frame_last;
        for (int k = 1; k < SGB_LAT - 1; k++) begin
            r_re_d[k]   <= r_re_d[k-1];
            r_im_d[k]   <= r_im_d[k-1];
            r_last_d[k] <= r_last_d[k-1];
        end
        r_out_real <= below ? '0 : r_re_d[SGB_LAT-2];
        r_out_imag <= below ? '0 : r_im_d[SGB_LAT-2];
        r_gated    <= below;
        r_out_last <= r_last_d[SGB_LAT-2];
    end

    sgb_weight #(
        .IDX_W(IDX_W)
    ) u_weight (
        .i_clk      (i_clk),
        .i_cfg      (r_cfg),
        .i_bin_index(i_bin_index),
        .o_weight   (weight)
    );

    sgb_mag #(
        .SW(SW)
    ) u_mag (
        .i_clk(i_clk),
        .i_re (i_bin_real),
        .i_im (i_bin_imag),
        .o_mag(mag)
    );

    sgb_gate #(
        .MAG_W(MAG_W)
    ) u_gate (
        .i_clk   (i_clk),
        .i_cfg   (r_cfg),
        .i_mag   (mag),
        .i_weight(weight),
        .o_below (below)
    );

    assign o_result_strobe = r_vld[SGB_LAT-1];
    assign o_out_real      = r_out_real;
    assign o_out_imag      = r_out_imag;
    assign o_gated         = r_gated;
    assign o_out_last      = r_out_last;

    `SGB_ASSERT(a_pass_real, i_clk, i_rst_n, o_result_strobe && !o_gated |-> o_out_real == $past(i_bin_real, SGB_LAT), "passed real part does not match its request")
    `SGB_ASSERT(a_last_align, i_clk, i_rst_n, o_result_strobe |-> o_out_last == $past(i_frame_last, SGB_LAT), "frame end marker out of step with its request")
    `SGB_ASSERT(a_gated_zero, i_clk, i_rst_n, o_result_strobe && o_gated |-> o_out_real == '0 && o_out_imag == '0, "gated bin carries nonzero data")
    `SGB_ASSERT(a_busy_stays_low, i_clk, i_rst_n, !o_busy |=> !o_busy, "busy rose outside reset")

endmodule
